// ===== design/binary_message_deframer_top_assert.svh =====
// Assertion macros used by the deframer checker.
`ifndef BINARY_MESSAGE_DEFRAMER_TOP_ASSERT_SVH
`define BINARY_MESSAGE_DEFRAMER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmd check failed: label");

// Consequent checked in the cycle after the antecedent.
`define BMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bmd check failed: label");

`endif

// ===== design/bmd_pkg.sv =====
// Types and constants of the binary message deframer.
`timescale 1ns / 1ps

package bmd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_PORT_HI,
        PH_PORT_LO,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_TEXT    = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FLAG_MASK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SHIFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_ONE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_TWO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_FOUR  = 3'd6;

    typedef struct packed {
        logic [7:0] flag_mask;
        logic [7:0] type_mask;
        logic [2:0] code_shift;
        logic [7:0] code_mask;
        logic [7:0] code_one;
        logic [7:0] code_two;
        logic [7:0] code_four;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  message_type;
        logic [15:0] port_id;
        logic [7:0]  data_byte;
        logic        last;
        logic [31:0] payload_value;
        logic [31:0] message_length;
    } t_result;

endpackage

// ===== design/bmd_cfg.sv =====
// Configuration register file of the deframer.
`timescale 1ns / 1ps

module bmd_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [bmd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bmd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output bmd_pkg::t_cfg                      o_cfg
);

    bmd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_mask  <= 8'd128;
            r_cfg.type_mask  <= 8'd15;
            r_cfg.code_shift <= 3'd4;
            r_cfg.code_mask  <= 8'd7;
            r_cfg.code_one   <= 8'd5;
            r_cfg.code_two   <= 8'd6;
            r_cfg.code_four  <= 8'd7;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bmd_pkg::REG_FLAG_MASK:  r_cfg.flag_mask  <= i_cfg_data;
                bmd_pkg::REG_TYPE_MASK:  r_cfg.type_mask  <= i_cfg_data;
                bmd_pkg::REG_CODE_SHIFT: r_cfg.code_shift <= i_cfg_data[2:0];
                bmd_pkg::REG_CODE_MASK:  r_cfg.code_mask  <= i_cfg_data;
                bmd_pkg::REG_CODE_ONE:   r_cfg.code_one   <= i_cfg_data;
                bmd_pkg::REG_CODE_TWO:   r_cfg.code_two   <= i_cfg_data;
                bmd_pkg::REG_CODE_FOUR:  r_cfg.code_four  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/bmd_core.sv =====
// Framing state machine: one stream byte in, at most one result out.
`timescale 1ns / 1ps

module bmd_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beat,
    input  logic [7:0]        i_byte,
    input  bmd_pkg::t_cfg     i_cfg,
    output logic              o_res_valid,
    output bmd_pkg::t_result  o_res
);

    localparam logic [LENGTH_BITS-1:0] L_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] L_TWO = LENGTH_BITS'(2);

    bmd_pkg::t_phase          r_phase, n_phase;
    logic [2:0]               r_len_left, n_len_left;
    logic [LENGTH_BITS-1:0]   r_len_accum, n_len_accum;
    logic [LENGTH_BITS-1:0]   r_bytes_left, n_bytes_left;
    logic [7:0]               r_type, n_type;
    logic [15:0]              r_port, n_port;
    logic [31:0]              r_value, n_value;

    logic [7:0]               code;
    logic                     start_go;
    logic                     value_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= bmd_pkg::PH_IDLE;
            r_len_left   <= '0;
            r_len_accum  <= '0;
            r_bytes_left <= '0;
            r_type       <= '0;
            r_port       <= '0;
            r_value      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_len_left   <= n_len_left;
            r_len_accum  <= n_len_accum;
            r_bytes_left <= n_bytes_left;
            r_type       <= n_type;
            r_port       <= n_port;
            r_value      <= n_value;
        end
    end

    // payload of 1, 2 or 4 bytes <=> total length 1, 3, 4 or 6
    assign value_ok = (r_len_accum == LENGTH_BITS'(1)) || (r_len_accum == LENGTH_BITS'(3)) ||
                      (r_len_accum == LENGTH_BITS'(4)) || (r_len_accum == LENGTH_BITS'(6));

    assign code = 8'(i_byte >> i_cfg.code_shift) & i_cfg.code_mask;

    always_comb begin
        n_phase      = r_phase;
        n_len_left   = r_len_left;
        n_len_accum  = r_len_accum;
        n_bytes_left = r_bytes_left;
        n_type       = r_type;
        n_port       = r_port;
        n_value      = r_value;
        start_go     = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_beat) begin
            case (r_phase)
                bmd_pkg::PH_LEN: begin
                    n_len_accum = {r_len_accum[LENGTH_BITS-9:0], i_byte};
                    n_len_left  = r_len_left - 3'd1;
                    start_go    = (n_len_left == 3'd0);
                end
                bmd_pkg::PH_PORT_HI: begin
                    n_port       = {i_byte, 8'h00};
                    n_bytes_left = r_bytes_left - L_ONE;
                    n_phase      = bmd_pkg::PH_PORT_LO;
                end
                bmd_pkg::PH_PORT_LO: begin
                    n_port       = {r_port[15:8], i_byte};
                    n_bytes_left = r_bytes_left - L_ONE;
                    if (n_bytes_left == '0) begin
                        o_res_valid          = 1'b1;
                        o_res.kind           = bmd_pkg::KIND_EMPTY;
                        o_res.message_type   = r_type;
                        o_res.port_id        = n_port;
                        o_res.last           = 1'b1;
                        o_res.message_length = 32'(r_len_accum);
                        n_phase              = bmd_pkg::PH_IDLE;
                    end else begin
                        n_phase = bmd_pkg::PH_PAYLOAD;
                    end
                end
                bmd_pkg::PH_PAYLOAD: begin
                    n_value              = {r_value[23:0], i_byte};
                    n_bytes_left         = r_bytes_left - L_ONE;
                    o_res_valid          = 1'b1;
                    o_res.kind           = bmd_pkg::KIND_PAYLOAD;
                    o_res.message_type   = r_type;
                    o_res.port_id        = r_port;
                    o_res.data_byte      = i_byte;
                    o_res.message_length = 32'(r_len_accum);
                    if (n_bytes_left == '0) begin
                        o_res.last          = 1'b1;
                        o_res.payload_value = value_ok ? n_value : 32'd0;
                        n_phase             = bmd_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = bmd_pkg::PH_IDLE;
                    if ((i_byte & i_cfg.flag_mask) == 8'd0) begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = bmd_pkg::KIND_TEXT;
                        o_res.data_byte = i_byte;
                    end else begin
                        n_type      = i_byte & i_cfg.type_mask;
                        n_len_accum = '0;
                        // first matching code wins
                        if (code == i_cfg.code_one) begin
                            n_len_left = 3'd1;
                            n_phase    = bmd_pkg::PH_LEN;
                        end else if (code == i_cfg.code_two) begin
                            n_len_left = 3'd2;
                            n_phase    = bmd_pkg::PH_LEN;
                        end else if (code == i_cfg.code_four) begin
                            n_len_left = 3'd4;
                            n_phase    = bmd_pkg::PH_LEN;
                        end else begin
                            n_len_accum = LENGTH_BITS'(code);
                            start_go    = 1'b1;
                        end
                    end
                end
            endcase

            // length now known: zero length is a framing error
            if (start_go) begin
                if (n_len_accum == '0) begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = bmd_pkg::KIND_ERROR;
                    o_res.message_type = n_type;
                    n_phase            = bmd_pkg::PH_IDLE;
                end else begin
                    n_bytes_left = n_len_accum;
                    n_port       = '0;
                    n_value      = '0;
                    n_phase      = (n_len_accum >= L_TWO) ? bmd_pkg::PH_PORT_HI
                                                          : bmd_pkg::PH_PAYLOAD;
                end
            end
        end
    end

endmodule

// ===== design/bmd_out.sv =====
// Result register with a skid entry, so input keeps flowing while one result waits.
`timescale 1ns / 1ps

module bmd_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  bmd_pkg::t_result  i_res,
    output logic              o_in_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output bmd_pkg::t_result  o_res
);

    logic             r_main_valid;
    logic             r_skid_valid;
    bmd_pkg::t_result r_main;
    bmd_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_main_valid) begin
            r_main <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_res      = r_main;

endmodule

// ===== design/binary_message_deframer_top.sv =====
// Top level of the binary message deframer.
`timescale 1ns / 1ps

// Binary message deframer: takes one stream byte per beat and splits text bytes from
// binary messages (header, optional length bytes, 2-byte port id, payload). The block
// accepts one byte every clock while tready is high; each byte is handled in a single
// pass of the framing state machine; its result, if any, is registered in the output
// register or its skid entry. The skid entry lets one further result in while a
// result is stalled, so s_axis tready drops only after two results are held back.
// Headers and length bytes produce no output beat unless the length is zero (framing
// error). Configuration writes are taken every cycle and should be made while idle.
module binary_message_deframer_top #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [bmd_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // [7:0] stream_byte
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] message_type, [23:8] port_id, [31:24] data_byte,
    // [63:32] payload_value, [95:64] message_length
    output logic [bmd_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic [bmd_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser,  // [1:0] kind
    output logic                                o_m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bmd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    bmd_pkg::t_cfg    cfg;
    bmd_pkg::t_result core_res;
    bmd_pkg::t_result out_res;
    logic             core_res_valid;
    logic             in_ready;
    logic             beat;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = in_ready;
    assign beat            = i_s_axis_tvalid && in_ready;

    bmd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bmd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_byte      (i_s_axis_tdata),
        .i_cfg       (cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    bmd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (core_res_valid),
        .i_res       (core_res),
        .o_in_ready  (in_ready),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (out_res)
    );

    assign o_m_axis_tdata = {out_res.message_length, out_res.payload_value,
                             out_res.data_byte, out_res.port_id, out_res.message_type};
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.last;

endmodule

// ===== design/bmd_checker.sv =====
// Port-level checks on the deframer output stream, bound to the top level.
`timescale 1ns / 1ps
`include "binary_message_deframer_top_assert.svh"

module bmd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [bmd_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic [bmd_pkg::OUT_TUSER_W-1:0]  o_m_axis_tuser,
    input logic                             o_m_axis_tlast
);

    logic [bmd_pkg::OUT_TDATA_W+bmd_pkg::OUT_TUSER_W:0] out_bus;
    logic [7:0]  msg_type;
    logic [15:0] port;
    logic [7:0]  data;
    logic [31:0] value;
    logic [31:0] length;
    logic        out_stall;
    logic        text_beat;
    logic        error_beat;
    logic        empty_beat;
    logic        text_ok;
    logic        error_ok;
    logic        empty_ok;

    assign out_bus  = {o_m_axis_tlast, o_m_axis_tuser, o_m_axis_tdata};
    assign msg_type = o_m_axis_tdata[7:0];
    assign port     = o_m_axis_tdata[23:8];
    assign data     = o_m_axis_tdata[31:24];
    assign value    = o_m_axis_tdata[63:32];
    assign length   = o_m_axis_tdata[95:64];

    assign out_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign text_beat  = o_m_axis_tvalid && o_m_axis_tuser == bmd_pkg::KIND_TEXT;
    assign error_beat = o_m_axis_tvalid && o_m_axis_tuser == bmd_pkg::KIND_ERROR;
    assign empty_beat = o_m_axis_tvalid && o_m_axis_tuser == bmd_pkg::KIND_EMPTY;

    assign text_ok  = !o_m_axis_tlast && {msg_type, port, value, length} == 88'd0;
    assign error_ok = !o_m_axis_tlast && {port, data, value, length} == 88'd0;
    assign empty_ok = o_m_axis_tlast && data == 8'd0 && value == 32'd0 && length == 32'd2;

    // a stalled output beat holds its contents
    `BMD_ASSERT_NEXT(a_out_hold, out_stall, o_m_axis_tvalid && $stable(out_bus))

    // text beats carry only the byte itself
    `BMD_ASSERT_NOW(a_text_clean, text_beat, text_ok)

    // framing errors carry the type only
    `BMD_ASSERT_NOW(a_error_clean, error_beat, error_ok)

    // an empty message is a whole message of length two
    `BMD_ASSERT_NOW(a_empty_last, empty_beat, empty_ok)

endmodule

bind binary_message_deframer_top bmd_checker u_bmd_checker (.*);
